>>> src/sme_pkg.sv
// Shared types and constants for the stack machine executor.
package sme_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OPC_W  = 4;
  localparam int unsigned ERR_W  = 2;

  // Instruction codes
  localparam logic [OPC_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OPC_W-1:0] OP_ADD   = 4'd1;
  localparam logic [OPC_W-1:0] OP_SUB   = 4'd2;
  localparam logic [OPC_W-1:0] OP_MUL   = 4'd3;
  localparam logic [OPC_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OPC_W-1:0] OP_PRINT = 4'd5;
  localparam logic [OPC_W-1:0] OP_INPUT = 4'd6;
  localparam logic [OPC_W-1:0] OP_DUP   = 4'd7;
  localparam logic [OPC_W-1:0] OP_SWAP  = 4'd8;
  localparam logic [OPC_W-1:0] OP_DROP  = 4'd9;
  localparam logic [OPC_W-1:0] OP_IF    = 4'd10;
  localparam logic [OPC_W-1:0] OP_ENDIF = 4'd11;
  localparam logic [OPC_W-1:0] OP_EQ    = 4'd12;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd3;

  // Divider iteration count
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DCNT_W    = 5;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_EQ
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_DONE
  } alu_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALU,
    ST_SWAP,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

>>> src/sme_stack_ram.sv
// Stack storage: one write port, two registered read ports.
module sme_stack_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [sme_pkg::DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0]         raddr0,
  input  logic [ADDR_W-1:0]         raddr1,
  output logic [sme_pkg::DATA_W-1:0] rdata0,
  output logic [sme_pkg::DATA_W-1:0] rdata1
);

  logic [sme_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> src/sme_alu.sv
// Shared arithmetic unit: add, sub, mul, eq in one step, iterative signed divide.
module sme_alu (
  input  logic              clk,
  input  logic              rst,
  input  sme_pkg::alu_req_t req,
  output sme_pkg::alu_rsp_t rsp
);

  sme_pkg::alu_state_t state, state_next;
  logic [sme_pkg::DATA_W-1:0] res, res_next;
  logic [sme_pkg::DATA_W-1:0] quo, quo_next;
  logic [sme_pkg::DATA_W-1:0] rem, rem_next;
  logic [sme_pkg::DATA_W-1:0] divisor, divisor_next;
  logic                       neg, neg_next;
  logic                       is_div, is_div_next;
  logic [sme_pkg::DCNT_W-1:0] cnt, cnt_next;

  logic [sme_pkg::DATA_W:0]   shifted;
  logic [sme_pkg::DATA_W:0]   trial;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sme_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    res     <= res_next;
    quo     <= quo_next;
    rem     <= rem_next;
    divisor <= divisor_next;
    neg     <= neg_next;
    is_div  <= is_div_next;
    cnt     <= cnt_next;
  end

  // One restoring step: shift in next dividend bit, try to subtract
  assign shifted = {rem, quo[sme_pkg::DATA_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  // Sequencing and operations
  always_comb begin
    state_next   = state;
    res_next     = res;
    quo_next     = quo;
    rem_next     = rem;
    divisor_next = divisor;
    neg_next     = neg;
    is_div_next  = is_div;
    cnt_next     = cnt;

    case (state)
      sme_pkg::A_IDLE: begin
        if (req.start) begin
          is_div_next = 1'b0;
          state_next  = sme_pkg::A_DONE;
          case (req.op)
            sme_pkg::ALU_ADD: res_next = req.a + req.b;
            sme_pkg::ALU_SUB: res_next = req.a - req.b;
            sme_pkg::ALU_MUL: res_next = req.a * req.b;
            sme_pkg::ALU_EQ:  res_next = {{(sme_pkg::DATA_W-1){1'b0}}, (req.a == req.b)};
            sme_pkg::ALU_DIV: begin
              // Work on magnitudes, fix the sign at the end
              quo_next     = req.a[sme_pkg::DATA_W-1] ? (32'd0 - req.a) : req.a;
              divisor_next = req.b[sme_pkg::DATA_W-1] ? (32'd0 - req.b) : req.b;
              neg_next     = req.a[sme_pkg::DATA_W-1] ^ req.b[sme_pkg::DATA_W-1];
              rem_next     = '0;
              cnt_next     = '0;
              is_div_next  = 1'b1;
              state_next   = sme_pkg::A_DIV;
            end
            default: res_next = '0;
          endcase
        end
      end
      sme_pkg::A_DIV: begin
        if (!trial[sme_pkg::DATA_W]) begin
          rem_next = trial[sme_pkg::DATA_W-1:0];
          quo_next = {quo[sme_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem_next = shifted[sme_pkg::DATA_W-1:0];
          quo_next = {quo[sme_pkg::DATA_W-2:0], 1'b0};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == sme_pkg::DCNT_W'(sme_pkg::DIV_STEPS - 1)) begin
          state_next = sme_pkg::A_DONE;
        end
      end
      sme_pkg::A_DONE: begin
        state_next = sme_pkg::A_IDLE;
      end
      default: begin
        state_next = sme_pkg::A_IDLE;
      end
    endcase
  end

  // Result
  assign rsp.done   = (state == sme_pkg::A_DONE);
  assign rsp.result = is_div ? (neg ? (32'd0 - quo) : quo) : res;

endmodule

>>> src/stack_machine_executor_unit.sv
// Stack machine executor: push/input/dup/print/drop/if/endif, errors, halted and skipped
// instructions pass ST_EXEC and ST_DONE before m_tvalid is registered; swap adds ST_SWAP,
// and add/sub/mul/eq/div add ST_ALU (32-step restoring divider in the shared unit).
// One instruction in flight: s_tready is high only while the sequencer idles, so the next
// accept waits for ST_DONE to pass the result on; it stalls while m_tvalid is high, m_tready low.
// Reset (synchronous, active high) clears count, nesting, halt and error; stack undefined.
module stack_machine_executor_unit #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned MAX_NESTING = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand
  input  logic [3:0]  s_tuser,   // [3:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] print_value, [33:32] error_code, [34] halted,
                                 // [35] skipping, [39:36] zero
  output logic        m_tuser    // [0] print_valid
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned NW = $clog2(MAX_NESTING + 1);

  sme_pkg::ctrl_state_t state, state_next;
  logic [CW-1:0]                  count, count_next;
  logic [NW-1:0]                  nest, nest_next;
  logic                           halt, halt_next;
  logic [sme_pkg::ERR_W-1:0]      err, err_next;
  logic [sme_pkg::OPC_W-1:0]      op, op_next;
  logic [sme_pkg::DATA_W-1:0]     opnd, opnd_next;
  logic                           pvalid, pvalid_next;
  logic [sme_pkg::DATA_W-1:0]     pv, pv_next;
  logic                           m_tvalid_next;
  logic [39:0]                    m_tdata_next;
  logic                           m_tuser_next;

  logic                           we;
  logic [IW-1:0]                  waddr;
  logic [sme_pkg::DATA_W-1:0]     wdata;
  logic [sme_pkg::DATA_W-1:0]     top, second;
  logic [CW-1:0]                  cm1, cm2;
  sme_pkg::alu_req_t              alu_req;
  sme_pkg::alu_rsp_t              alu_rsp;

  assign cm1 = count - CW'(1);
  assign cm2 = count - CW'(2);

  // Stack memory, read at top and second from top
  sme_stack_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (IW)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (cm1[IW-1:0]),
    .raddr1 (cm2[IW-1:0]),
    .rdata0 (top),
    .rdata1 (second)
  );

  // Shared arithmetic unit
  sme_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sme_pkg::ST_IDLE;
      count    <= '0;
      nest     <= '0;
      halt     <= 1'b0;
      err      <= sme_pkg::ERR_NONE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      nest     <= nest_next;
      halt     <= halt_next;
      err      <= err_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op      <= op_next;
    opnd    <= opnd_next;
    pvalid  <= pvalid_next;
    pv      <= pv_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    nest_next     = nest;
    halt_next     = halt;
    err_next      = err;
    op_next       = op;
    opnd_next     = opnd;
    pvalid_next   = pvalid;
    pv_next       = pv;
    m_tvalid_next = m_tvalid & ~m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    alu_req       = '0;
    s_tready      = (state == sme_pkg::ST_IDLE);

    case (state)
      sme_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          op_next     = s_tuser;
          opnd_next   = s_tdata;
          pvalid_next = 1'b0;
          pv_next     = '0;
          state_next  = sme_pkg::ST_EXEC;
        end
      end

      sme_pkg::ST_EXEC: begin
        state_next = sme_pkg::ST_DONE;
        if (halt) begin
          // halted: ignore
        end else if (nest != '0) begin
          // skipping: only if/endif track nesting
          if (op == sme_pkg::OP_IF) begin
            if (nest < NW'(MAX_NESTING)) begin
              nest_next = nest + NW'(1);
            end
          end else if (op == sme_pkg::OP_ENDIF) begin
            nest_next = nest - NW'(1);
          end
        end else begin
          case (op)
            sme_pkg::OP_PUSH, sme_pkg::OP_INPUT: begin
              if (count == CW'(STACK_DEPTH)) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_OVER;
              end else begin
                we         = 1'b1;
                waddr      = count[IW-1:0];
                wdata      = opnd;
                count_next = count + CW'(1);
              end
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_EQ,
            sme_pkg::OP_DIV: begin
              if (count < CW'(2)) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else if (op == sme_pkg::OP_DIV && top == '0) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_DIVZ;
              end else begin
                alu_req.start = 1'b1;
                alu_req.a     = second;
                alu_req.b     = top;
                case (op)
                  sme_pkg::OP_ADD: alu_req.op = sme_pkg::ALU_ADD;
                  sme_pkg::OP_SUB: alu_req.op = sme_pkg::ALU_SUB;
                  sme_pkg::OP_MUL: alu_req.op = sme_pkg::ALU_MUL;
                  sme_pkg::OP_DIV: alu_req.op = sme_pkg::ALU_DIV;
                  default:         alu_req.op = sme_pkg::ALU_EQ;
                endcase
                state_next = sme_pkg::ST_ALU;
              end
            end
            sme_pkg::OP_PRINT: begin
              if (count == '0) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else begin
                pvalid_next = 1'b1;
                pv_next     = top;
                count_next  = cm1;
              end
            end
            sme_pkg::OP_DUP: begin
              if (count == '0) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else if (count == CW'(STACK_DEPTH)) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_OVER;
              end else begin
                we         = 1'b1;
                waddr      = count[IW-1:0];
                wdata      = top;
                count_next = count + CW'(1);
              end
            end
            sme_pkg::OP_SWAP: begin
              if (count < CW'(2)) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else begin
                // second goes on top now, old top written next cycle
                we         = 1'b1;
                waddr      = cm1[IW-1:0];
                wdata      = second;
                opnd_next  = top;
                state_next = sme_pkg::ST_SWAP;
              end
            end
            sme_pkg::OP_DROP: begin
              if (count == '0) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else begin
                count_next = cm1;
              end
            end
            sme_pkg::OP_IF: begin
              if (count == '0) begin
                halt_next = 1'b1;
                err_next  = sme_pkg::ERR_UNDER;
              end else begin
                count_next = cm1;
                if (top == '0) begin
                  nest_next = NW'(1);
                end
              end
            end
            default: begin
              // endif outside a skip and unused codes: no effect
            end
          endcase
        end
      end

      // Wait for the shared unit, then replace the two operands by the result
      sme_pkg::ST_ALU: begin
        if (alu_rsp.done) begin
          we         = 1'b1;
          waddr      = cm2[IW-1:0];
          wdata      = alu_rsp.result;
          count_next = cm1;
          state_next = sme_pkg::ST_DONE;
        end
      end

      sme_pkg::ST_SWAP: begin
        we         = 1'b1;
        waddr      = cm2[IW-1:0];
        wdata      = opnd;
        state_next = sme_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free
      sme_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = pvalid;
          m_tdata_next  = {4'b0000, (nest != '0), halt, err, pv};
          state_next    = sme_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sme_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
